/* rtl/core/spc_pkg.sv */
// Shared types, constants and result builder for the servo status packet checker.
package spc_pkg;

  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_BYTE   = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] CFG_EXPECTED_ID     = 2'd0;
  localparam logic [1:0] CFG_EXPECTED_LENGTH = 2'd1;
  localparam logic [1:0] CFG_IDLE_LIMIT      = 2'd2;
  localparam logic [1:0] CFG_NONE            = 2'd3;

  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IDLE_TICK_W = 17;

  localparam logic [7:0]  BROADCAST_ID     = 8'd254;
  localparam logic [7:0]  HEADER_BYTE      = 8'hFF;
  localparam logic [7:0]  CHECKSUM_GOOD    = 8'hFF;
  localparam logic [7:0]  LENGTH_UNBOUNDED = 8'd255;
  localparam logic [7:0]  HEADER_BYTES     = 8'd3;
  localparam logic [7:0]  LENGTH_OFFSET    = 8'd4;
  localparam logic [15:0] IDLE_LIMIT_RESET = 16'd3000;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } spc_in_t;

  typedef struct packed {
    logic [7:0] received_count;
    logic       timeout_error;
    logic       header_error;
    logic       id_error;
    logic       length_error;
    logic       checksum_error;
  } spc_out_t;

  typedef struct packed {
    logic    valid;
    spc_in_t data;
  } spc_item_t;

  typedef struct packed {
    logic     valid;
    spc_out_t data;
  } spc_result_t;

  function automatic spc_out_t make_result(
    input logic [7:0] count,
    input logic       timed_out,
    input logic       header_bad,
    input logic       id_bad,
    input logic [7:0] length_field,
    input logic [7:0] running_sum,
    input logic [7:0] expected_id,
    input logic [7:0] expected_length
  );
    spc_out_t r;
    logic     checked;
    logic     full;
    checked = (expected_id != BROADCAST_ID);
    full    = checked && (count > HEADER_BYTES);
    r.received_count = count;
    r.timeout_error  = checked && timed_out && (expected_length != LENGTH_UNBOUNDED);
    r.header_error   = full && header_bad;
    r.id_error       = full && id_bad;
    r.length_error   = full && (length_field != (count - LENGTH_OFFSET));
    r.checksum_error = full && (running_sum != CHECKSUM_GOOD);
    return r;
  endfunction

endpackage

/* rtl/core/spc_in_stage.sv */
// Input register stage: holds one request until the step logic takes it.
module spc_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  spc_pkg::spc_in_t   in_data,
  output spc_pkg::spc_item_t item,
  input  logic               take
);
  import spc_pkg::*;

  logic    valid_q;
  spc_in_t data_q;

  assign in_stall   = valid_q && !take;
  assign item.valid = valid_q;
  assign item.data  = data_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (!in_stall) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      data_q <= in_data;
    end
  end

endmodule

/* rtl/core/spc_step.sv */
// Configuration registers, reception state and the per-request update logic.
module spc_step (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  spc_pkg::spc_item_t    item,
  input  logic                  take,
  output spc_pkg::spc_result_t  result
);
  import spc_pkg::*;

  logic [7:0]             expected_id;
  logic [7:0]             expected_length;
  logic [15:0]            idle_limit;

  logic                   active;
  logic [7:0]             byte_count;
  logic [IDLE_TICK_W-1:0] idle_ticks;
  logic [7:0]             running_sum;
  logic                   header_bad;
  logic                   id_bad;
  logic [7:0]             length_field;

  logic                   active_next;
  logic [7:0]             byte_count_next;
  logic [IDLE_TICK_W-1:0] idle_ticks_next;
  logic [7:0]             running_sum_next;
  logic                   header_bad_next;
  logic                   id_bad_next;
  logic [7:0]             length_field_next;
  logic                   push;
  logic                   timed_out;
  logic                   fire;
  logic [7:0]             b;

  assign fire = item.valid && take;
  assign b    = item.data.data_byte;

  always_comb begin
    active_next       = active;
    byte_count_next   = byte_count;
    idle_ticks_next   = idle_ticks;
    running_sum_next  = running_sum;
    header_bad_next   = header_bad;
    id_bad_next       = id_bad;
    length_field_next = length_field;
    push              = 1'b0;
    timed_out         = 1'b0;
    if (fire) begin
      unique case (item.data.mode)
        MODE_START: begin
          byte_count_next   = '0;
          idle_ticks_next   = '0;
          running_sum_next  = '0;
          header_bad_next   = 1'b0;
          id_bad_next       = 1'b0;
          length_field_next = '0;
          if (expected_length == '0) begin
            push        = 1'b1;
            active_next = 1'b0;
          end else begin
            active_next = 1'b1;
          end
        end
        MODE_BYTE: begin
          if (active) begin
            if (byte_count < 8'd2) begin
              if (b != HEADER_BYTE) begin
                header_bad_next = 1'b1;
              end
            end else begin
              if (byte_count == 8'd2) begin
                id_bad_next = (b != expected_id);
              end else if (byte_count == HEADER_BYTES) begin
                length_field_next = b;
              end
              running_sum_next = running_sum + b;
            end
            byte_count_next = byte_count + 8'd1;
            idle_ticks_next = '0;
            if (byte_count_next >= expected_length) begin
              push        = 1'b1;
              active_next = 1'b0;
            end
          end
        end
        MODE_TICK: begin
          if (active) begin
            if (idle_ticks > {1'b0, idle_limit}) begin
              push        = 1'b1;
              timed_out   = 1'b1;
              active_next = 1'b0;
            end else begin
              idle_ticks_next = idle_ticks + IDLE_TICK_W'(1);
            end
          end
        end
        MODE_UNUSED: begin
        end
        default: begin
        end
      endcase
    end
    result.valid = push;
    result.data  = make_result(byte_count_next, timed_out, header_bad_next, id_bad_next,
                               length_field_next, running_sum_next, expected_id,
                               expected_length);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id     <= '0;
      expected_length <= '0;
      idle_limit      <= IDLE_LIMIT_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_EXPECTED_ID:     expected_id     <= cfg_data[7:0];
        CFG_EXPECTED_LENGTH: expected_length <= cfg_data[7:0];
        CFG_IDLE_LIMIT:      idle_limit      <= cfg_data[CFG_DATA_W-1:0];
        CFG_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      byte_count   <= '0;
      idle_ticks   <= '0;
      running_sum  <= '0;
      header_bad   <= 1'b0;
      id_bad       <= 1'b0;
      length_field <= '0;
    end else begin
      active       <= active_next;
      byte_count   <= byte_count_next;
      idle_ticks   <= idle_ticks_next;
      running_sum  <= running_sum_next;
      header_bad   <= header_bad_next;
      id_bad       <= id_bad_next;
      length_field <= length_field_next;
    end
  end

endmodule

/* rtl/core/spc_out_stage.sv */
// Result register: holds a finished result until the receiver takes it.
module spc_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  spc_pkg::spc_result_t result,
  output logic                 take,
  output logic                 out_valid,
  input  logic                 out_stall,
  output spc_pkg::spc_out_t    out_data
);
  import spc_pkg::*;

  logic     valid_q;
  spc_out_t data_q;

  assign take      = !valid_q || !out_stall;
  assign out_valid = valid_q;
  assign out_data  = data_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && result.valid) begin
      data_q <= result.data;
    end
  end

endmodule

/* rtl/core/servo_status_packet_checker_unit.sv */
// Servo status packet checker, top level.
// Takes one request per cycle (start, received byte or idle tick) and returns at most one
// result per request. A request is registered in the input register on acceptance; the step logic
// then updates the reception state and loads any result into the output register at the same edge,
// which drives out_valid. Throughput is one request per cycle while out_stall is low.
// A stalled result holds the step logic; in_stall follows out_stall in the same cycle
// when both the input register and the output register are occupied. Configuration writes take
// effect at once; they must be made while no request is in flight, which the block itself
// does not enforce.
module servo_status_packet_checker_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  spc_pkg::spc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output spc_pkg::spc_out_t out_data,
  input  logic              cfg_write_en,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import spc_pkg::*;

  spc_item_t   item;
  spc_result_t result;
  logic        take;

  spc_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .item     (item),
    .take     (take)
  );

  spc_step u_step (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .take         (take),
    .result       (result)
  );

  spc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .result    (result),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* rtl/core/spc_checker.sv */
// Port-level checks for the servo status packet checker, bound to the top level.
module spc_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input spc_pkg::spc_out_t out_data
);
  import spc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while result register empty");

  a_short_packet_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.received_count <= HEADER_BYTES) |->
      !out_data.header_error && !out_data.id_error &&
      !out_data.length_error && !out_data.checksum_error)
    else $error("packet flags set on short reception");

  a_stall_needs_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

endmodule

bind servo_status_packet_checker_unit spc_checker u_spc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
